@@ rtl/brd_pkg.sv @@
// Package for the bitmap RLE8/RLE4 run decoder.
// Holds command codes, register indexes and stream field widths.
// No dependencies.
package brd_pkg;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned RgbW     = 24;
  localparam int unsigned CoordW   = 12;
  localparam int unsigned PosW     = 16;
  localparam int unsigned DimRegW  = 13;
  localparam int unsigned CfgAddrW = 2;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 80;

  localparam logic [CmdW-1:0] CmdData    = 2'd0;
  localparam logic [CmdW-1:0] CmdPalette = 2'd1;
  localparam logic [CmdW-1:0] CmdStart   = 2'd2;

  localparam logic [CfgAddrW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgAddrW-1:0] RegHeight = 2'd1;
  localparam logic [CfgAddrW-1:0] RegFour   = 2'd2;

  localparam logic [ByteW-1:0] EscLead  = 8'd0;
  localparam logic [ByteW-1:0] EscEol   = 8'd0;
  localparam logic [ByteW-1:0] EscEob   = 8'd1;
  localparam logic [ByteW-1:0] EscDelta = 8'd2;

  typedef struct packed {
    logic [RgbW-1:0]   color_odd;
    logic [RgbW-1:0]   color_even;
    logic [ByteW-1:0]  run_length;
    logic [CoordW-1:0] start_column;
    logic [CoordW-1:0] buffer_row;
  } out_data_t;

endpackage

@@ rtl/bmp_rle_run_decoder.sv @@
// Top level of the bitmap RLE8/RLE4 run decoder: stream parser and run output.
// Depends on brd_pkg and brd_ram (two palette copies, one per nibble color).
//
//  channel   dir  handshake                   payload
//  s_axis    in   tvalid/tready               tuser command, tdata byte/palette, tlast eod
//  m_axis    out  tvalid/tready               tdata run fields, tlast image done
//  cfg       in   cfg_we_i                    cfg_addr_i register index, cfg_wdata_i value
//
// One item is taken per cycle while s_axis_tready is high.
// The parser updates its state in the accept cycle and reads the palette RAMs, whose
// registered data is joined with the run fields in the following output register.
// Reset clears the parser and the valid flags; the palette is undefined until written.
// A stall on m_axis holds the pipeline and drops s_axis_tready once both stages are full.
module bmp_rle_run_decoder #(
  parameter int unsigned MAX_DIM       = 4096,
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: data_byte [7:0], palette_index [15:8], palette_rgb [39:16]
  input  logic [brd_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: command [1:0]
  input  logic [brd_pkg::CmdW-1:0]     s_axis_tuser,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: buffer_row [11:0], start_column [23:12], run_length [31:24],
  // color_even [55:32], color_odd [79:56]
  output logic [brd_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast,
  input  logic                         cfg_we_i,
  input  logic [brd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [brd_pkg::DimRegW-1:0]  cfg_wdata_i
);

  localparam int unsigned PalAw = $clog2(PALETTE_DEPTH);
  localparam logic [brd_pkg::PosW-1:0] MaxDim = brd_pkg::PosW'(MAX_DIM);
  localparam logic [brd_pkg::ByteW:0] PalDepth = (brd_pkg::ByteW+1)'(PALETTE_DEPTH);

  typedef enum logic [2:0] {
    PhCount, PhColor, PhEscape, PhDeltaX, PhDeltaY, PhAbs, PhPad
  } phase_e;

  logic [brd_pkg::DimRegW-1:0] width_q, height_q;
  logic                        rle4_q;

  phase_e                      phase_q, phase_d;
  logic [brd_pkg::ByteW-1:0]   count_q, count_d;
  logic [brd_pkg::ByteW-1:0]   left_q, left_d;
  logic                        pad_q, pad_d;
  logic [brd_pkg::PosW-1:0]    column_q, column_d;
  logic [brd_pkg::PosW-1:0]    row_q, row_d;
  logic                        finished_q, finished_d;

  logic                        p_valid_q, p_done_q, p_ezero_q, p_ozero_q;
  logic [brd_pkg::CoordW-1:0]  p_row_q, p_col_q;
  logic [brd_pkg::ByteW-1:0]   p_len_q;
  logic                        o_valid_q, o_last_q;
  brd_pkg::out_data_t          o_data_q;

  logic [brd_pkg::CmdW-1:0]    cmd;
  logic [brd_pkg::ByteW-1:0]   b, pidx;
  logic [brd_pkg::RgbW-1:0]    prgb;
  logic                        acc, move, data_go, pal_we;
  logic [brd_pkg::PosW-1:0]    w16, h16, room, buf_row;
  logic                        draw, done, emit, col_in, res_valid, b_in_pal;
  logic [brd_pkg::ByteW-1:0]   n, take;
  logic [PalAw-1:0]            addr_even, addr_odd;
  logic [brd_pkg::RgbW-1:0]    rd_even, rd_odd;

  assign cmd  = s_axis_tuser;
  assign b    = s_axis_tdata[7:0];
  assign pidx = s_axis_tdata[15:8];
  assign prgb = s_axis_tdata[39:16];

  assign move          = p_valid_q && (!o_valid_q || m_axis_tready);
  assign s_axis_tready = !p_valid_q || !o_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign data_go       = acc && (cmd == brd_pkg::CmdData) && !finished_q;
  assign b_in_pal      = {1'b0, b} < PalDepth;
  assign pal_we        = acc && (cmd == brd_pkg::CmdPalette) && ({1'b0, pidx} < PalDepth);

  assign w16 = ({3'b0, width_q} > MaxDim) ? MaxDim : {3'b0, width_q};
  assign h16 = ({3'b0, height_q} > MaxDim) ? MaxDim : {3'b0, height_q};

  assign addr_even = rle4_q ? PalAw'(b[7:4]) : b[PalAw-1:0];
  assign addr_odd  = rle4_q ? PalAw'(b[3:0]) : b[PalAw-1:0];

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    left_d     = left_q;
    pad_d      = pad_q;
    row_d      = row_q;
    done       = s_axis_tlast;
    draw       = 1'b0;
    n          = count_q;
    unique case (phase_q)
      PhCount: begin
        if (b != brd_pkg::EscLead) begin
          count_d = b;
          phase_d = PhColor;
        end else begin
          phase_d = PhEscape;
        end
      end
      PhColor: begin
        draw    = 1'b1;
        phase_d = PhCount;
      end
      PhEscape: begin
        priority if (b == brd_pkg::EscEol) begin
          row_d   = row_q + 16'd1;
          phase_d = PhCount;
        end else if (b == brd_pkg::EscEob) begin
          done    = 1'b1;
          phase_d = PhCount;
        end else if (b == brd_pkg::EscDelta) begin
          phase_d = PhDeltaX;
        end else begin
          left_d  = b;
          pad_d   = rle4_q ? (b[1] ^ b[0]) : b[0];
          phase_d = PhAbs;
        end
      end
      PhDeltaX: phase_d = PhDeltaY;
      PhDeltaY: begin
        row_d   = row_q + {8'd0, b};
        phase_d = PhCount;
      end
      PhAbs: begin
        draw   = 1'b1;
        n      = (rle4_q && left_q >= 8'd2) ? 8'd2 : (rle4_q ? left_q : 8'd1);
        left_d = left_q - n;
        if (left_d == 8'd0) begin
          phase_d = pad_q ? PhPad : PhCount;
        end
      end
      default: phase_d = PhCount;
    endcase
  end

  assign col_in  = column_q < w16;
  assign room    = w16 - column_q;
  assign take    = (room < {8'd0, n}) ? room[7:0] : n;
  assign emit    = draw && col_in && (row_q < h16) && (take != 8'd0);
  assign buf_row = h16 - 16'd1 - row_q;

  always_comb begin
    column_d = column_q;
    if (draw && col_in) begin
      column_d = column_q + {8'd0, take};
    end else if (phase_q == PhEscape && b == brd_pkg::EscEol) begin
      column_d = '0;
    end else if (phase_q == PhDeltaX) begin
      column_d = column_q + {8'd0, b};
    end
  end

  assign finished_d = done;
  assign res_valid  = emit || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= brd_pkg::DimRegW'(1);
      height_q <= brd_pkg::DimRegW'(1);
      rle4_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        brd_pkg::RegWidth:  width_q  <= cfg_wdata_i;
        brd_pkg::RegHeight: height_q <= cfg_wdata_i;
        brd_pkg::RegFour:   rle4_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhCount;
      count_q    <= '0;
      left_q     <= '0;
      pad_q      <= 1'b0;
      column_q   <= '0;
      row_q      <= '0;
      finished_q <= 1'b0;
    end else if (acc && cmd == brd_pkg::CmdStart) begin
      phase_q    <= PhCount;
      count_q    <= '0;
      left_q     <= '0;
      pad_q      <= 1'b0;
      column_q   <= '0;
      row_q      <= '0;
      finished_q <= 1'b0;
    end else if (data_go) begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      left_q     <= left_d;
      pad_q      <= pad_d;
      column_q   <= column_d;
      row_q      <= row_d;
      finished_q <= finished_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        p_valid_q <= data_go && res_valid;
      end else if (move) begin
        p_valid_q <= 1'b0;
      end
      if (move) begin
        o_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      p_done_q  <= done;
      p_row_q   <= emit ? buf_row[brd_pkg::CoordW-1:0] : '0;
      p_col_q   <= emit ? column_q[brd_pkg::CoordW-1:0] : '0;
      p_len_q   <= emit ? take : '0;
      p_ezero_q <= !emit || (!rle4_q && !b_in_pal);
      p_ozero_q <= !emit || (!rle4_q && !b_in_pal);
    end
    if (move) begin
      o_last_q              <= p_done_q;
      o_data_q.buffer_row   <= p_row_q;
      o_data_q.start_column <= p_col_q;
      o_data_q.run_length   <= p_len_q;
      o_data_q.color_even   <= p_ezero_q ? '0 : rd_even;
      o_data_q.color_odd    <= p_ozero_q ? '0 : rd_odd;
    end
  end

  brd_ram #(.Width(brd_pkg::RgbW), .Depth(PALETTE_DEPTH)) u_pal_even (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pidx[PalAw-1:0]),
    .wdata_i (prgb),
    .re_i    (data_go),
    .raddr_i (addr_even),
    .rdata_o (rd_even)
  );

  brd_ram #(.Width(brd_pkg::RgbW), .Depth(PALETTE_DEPTH)) u_pal_odd (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pidx[PalAw-1:0]),
    .wdata_i (prgb),
    .re_i    (data_go),
    .raddr_i (addr_odd),
    .rdata_o (rd_odd)
  );

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = o_data_q;
  assign m_axis_tlast  = o_last_q;

endmodule

@@ rtl/brd_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module brd_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/brd_checker.sv @@
// Port-level checks for the bitmap RLE run decoder output stream.
// Depends on brd_pkg; bound to bmp_rle_run_decoder at the end of this file.
module brd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [brd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tlast
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  a_empty_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[31:24] == 8'd0 |-> m_axis_tlast)
    else $error("empty run without image done");

  a_empty_run_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[31:24] == 8'd0 |-> m_axis_tdata == '0)
    else $error("done-only item carries nonzero fields");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind bmp_rle_run_decoder brd_checker u_brd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

@@ bench/bmp_rle_run_decoder_tb.sv @@
// Self-checking testbench for bmp_rle_run_decoder: RLE8/RLE4 streams in, pixel runs out.
// A built-in decoder model predicts every run; needs brd_pkg and the decoder RTL.
// Both stream sides idle in random bursts; the shape registers change between phases.
`timescale 1ns / 100ps

module bmp_rle_run_decoder_tb;

  localparam int unsigned MaxDim     = 4096;
  localparam int unsigned StuckLimit = 2000;
  localparam logic [brd_pkg::CmdW-1:0] CmdUnused = 2'd3;

  typedef logic [brd_pkg::ByteW-1:0]   byte_t;
  typedef logic [brd_pkg::RgbW-1:0]    rgb_t;
  typedef logic [brd_pkg::DimRegW-1:0] dim_t;

  typedef enum logic [2:0] {
    PhCount, PhColor, PhEscape, PhDeltaX, PhDeltaY, PhAbs, PhPad
  } parse_phase_e;

  typedef struct {
    logic [brd_pkg::CmdW-1:0]  cmd;
    logic [brd_pkg::ByteW-1:0] data_byte;
    logic                      eod;
    logic [brd_pkg::ByteW-1:0] pidx;
    logic [brd_pkg::RgbW-1:0]  rgb;
  } stream_item_t;

  typedef struct packed {
    brd_pkg::out_data_t data;
    logic               done;
  } run_rec_t;

  logic                           clk_i;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [brd_pkg::InDataW-1:0]    s_axis_tdata  = '0;
  logic [brd_pkg::CmdW-1:0]       s_axis_tuser  = brd_pkg::CmdData;
  logic                           s_axis_tlast  = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [brd_pkg::OutDataW-1:0]   m_axis_tdata;
  logic                           m_axis_tlast;
  logic                           cfg_we_i      = 1'b0;
  logic [brd_pkg::CfgAddrW-1:0]   cfg_addr_i    = brd_pkg::RegWidth;
  logic [brd_pkg::DimRegW-1:0]    cfg_wdata_i   = '0;

  stream_item_t items_waiting[$];
  stream_item_t cur_item;
  run_rec_t     runs_due[$];

  int unsigned src_gap_pct   = 0;
  int unsigned dst_gap_pct   = 0;
  int unsigned src_idle_left = 0;
  int unsigned dst_idle_left = 0;
  int unsigned mismatches    = 0;
  int unsigned stuck_cycles  = 0;

  logic [brd_pkg::DimRegW-1:0] reg_width  = 13'd1;
  logic [brd_pkg::DimRegW-1:0] reg_height = 13'd1;
  logic                        reg_four   = 1'b0;

  parse_phase_e                dec_phase = PhCount;
  logic [brd_pkg::ByteW-1:0]   dec_count = '0;
  logic [brd_pkg::ByteW-1:0]   dec_left  = '0;
  logic                        dec_pad   = 1'b0;
  logic [brd_pkg::PosW-1:0]    dec_col   = '0;
  logic [brd_pkg::PosW-1:0]    dec_row   = '0;
  logic                        dec_done  = 1'b0;
  logic [brd_pkg::RgbW-1:0]    palette_copy [256];

  bmp_rle_run_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(input logic [brd_pkg::DimRegW-1:0] v);
    return (v > MaxDim) ? MaxDim : int'(v);
  endfunction

  task automatic paint_span(input int unsigned n, input logic [brd_pkg::RgbW-1:0] ce,
                            input logic [brd_pkg::RgbW-1:0] co,
                            output brd_pkg::out_data_t d, output int unsigned len);
    int unsigned w, h, room, take, brow;
    w = clamp_dim(reg_width);
    h = clamp_dim(reg_height);
    d = '0;
    len = 0;
    if (dec_col < w) begin
      room = w - dec_col;
      take = (n < room) ? n : room;
      if (dec_row < h && take > 0) begin
        brow = h - 1 - dec_row;
        d.buffer_row   = brow[brd_pkg::CoordW-1:0];
        d.start_column = dec_col[brd_pkg::CoordW-1:0];
        d.run_length   = take[brd_pkg::ByteW-1:0];
        d.color_even   = ce;
        d.color_odd    = co;
        len = take;
      end
      dec_col = dec_col + take[brd_pkg::PosW-1:0];
    end
  endtask

  task automatic decode_item(input stream_item_t it);
    run_rec_t                  r;
    int unsigned               len, n, nb;
    logic [brd_pkg::ByteW-1:0] b;
    logic                      fin;
    r = '0;
    len = 0;
    fin = 1'b0;
    b = it.data_byte;
    case (it.cmd)
      brd_pkg::CmdPalette: palette_copy[it.pidx] = it.rgb;
      brd_pkg::CmdStart: begin
        dec_phase = PhCount;
        dec_count = '0;
        dec_left  = '0;
        dec_pad   = 1'b0;
        dec_col   = '0;
        dec_row   = '0;
        dec_done  = 1'b0;
      end
      brd_pkg::CmdData: if (!dec_done) begin
        case (dec_phase)
          PhCount: begin
            if (b != brd_pkg::EscLead) begin
              dec_count = b;
              dec_phase = PhColor;
            end else begin
              dec_phase = PhEscape;
            end
          end
          PhColor: begin
            if (reg_four)
              paint_span(int'(dec_count), palette_copy[b[7:4]], palette_copy[b[3:0]],
                         r.data, len);
            else
              paint_span(int'(dec_count), palette_copy[b], palette_copy[b], r.data, len);
            dec_phase = PhCount;
          end
          PhEscape: begin
            if (b == brd_pkg::EscEol) begin
              dec_col = '0;
              dec_row = dec_row + 16'd1;
              dec_phase = PhCount;
            end else if (b == brd_pkg::EscEob) begin
              fin = 1'b1;
              dec_phase = PhCount;
            end else if (b == brd_pkg::EscDelta) begin
              dec_phase = PhDeltaX;
            end else begin
              nb = reg_four ? ((int'(b) + 1) >> 1) : int'(b);
              dec_left = b;
              dec_pad = nb[0];
              dec_phase = PhAbs;
            end
          end
          PhDeltaX: begin
            dec_col = dec_col + {8'd0, b};
            dec_phase = PhDeltaY;
          end
          PhDeltaY: begin
            dec_row = dec_row + {8'd0, b};
            dec_phase = PhCount;
          end
          PhAbs: begin
            if (reg_four) begin
              n = (dec_left < 2) ? int'(dec_left) : 2;
              paint_span(n, palette_copy[b[7:4]], palette_copy[b[3:0]], r.data, len);
            end else begin
              n = 1;
              paint_span(n, palette_copy[b], palette_copy[b], r.data, len);
            end
            if (dec_left >= n)
              dec_left = dec_left - n[brd_pkg::ByteW-1:0];
            else
              dec_left = '0;
            if (dec_left == 0)
              dec_phase = dec_pad ? PhPad : PhCount;
          end
          default: dec_phase = PhCount;
        endcase
        if (it.eod)
          fin = 1'b1;
        if (fin) begin
          dec_done = 1'b1;
          if (len == 0)
            r.data = '0;
          r.done = 1'b1;
          runs_due.push_back(r);
        end else if (len > 0) begin
          runs_due.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : src_drive
    logic nv;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        decode_item(cur_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        nv = 1'b0;
        if (src_idle_left > 0) begin
          src_idle_left--;
        end else if (items_waiting.size() != 0) begin
          if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
            src_idle_left = $urandom_range(6, 0);
          end else begin
            cur_item = items_waiting.pop_front();
            nv = 1'b1;
            s_axis_tdata <= {cur_item.rgb, cur_item.pidx, cur_item.data_byte};
            s_axis_tuser <= cur_item.cmd;
            s_axis_tlast <= cur_item.eod;
          end
        end
        s_axis_tvalid <= nv;
      end
    end
  end

  always @(posedge clk_i) begin : run_check
    brd_pkg::out_data_t got;
    run_rec_t           want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (runs_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected run: row %0d col %0d len %0d even %h odd %h done %0b",
                     got.buffer_row, got.start_column, got.run_length, got.color_even,
                     got.color_odd, m_axis_tlast);
        end else begin
          want = runs_due.pop_front();
          if (got.buffer_row !== want.data.buffer_row ||
              got.start_column !== want.data.start_column ||
              got.run_length !== want.data.run_length ||
              got.color_even !== want.data.color_even ||
              got.color_odd !== want.data.color_odd ||
              m_axis_tlast !== want.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"run mismatch: want row %0d col %0d len %0d even %h odd %h done %0b,",
                        " got row %0d col %0d len %0d even %h odd %h done %0b"},
                       want.data.buffer_row, want.data.start_column, want.data.run_length,
                       want.data.color_even, want.data.color_odd, want.done,
                       got.buffer_row, got.start_column, got.run_length, got.color_even,
                       got.color_odd, m_axis_tlast);
          end
        end
      end
      if (dst_idle_left > 0) begin
        dst_idle_left--;
        m_axis_tready <= 1'b0;
      end else if (dst_gap_pct != 0 && $urandom_range(99) < dst_gap_pct) begin
        dst_idle_left = $urandom_range(6, 0);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= StuckLimit);
    $display("simulation failed");
    $finish;
  end

  task automatic push_item(input logic [brd_pkg::CmdW-1:0] cmd,
                           input logic [brd_pkg::ByteW-1:0] b, input logic eod,
                           input logic [brd_pkg::ByteW-1:0] pidx,
                           input logic [brd_pkg::RgbW-1:0] rgb);
    stream_item_t it;
    it.cmd = cmd;
    it.data_byte = b;
    it.eod = eod;
    it.pidx = pidx;
    it.rgb = rgb;
    items_waiting.push_back(it);
  endtask

  task automatic send(input logic [brd_pkg::CmdW-1:0] cmd, input logic [brd_pkg::ByteW-1:0] b,
                      input logic eod);
    push_item(cmd, b, eod, byte_t'($urandom), rgb_t'($urandom));
  endtask

  task automatic write_reg(input logic [brd_pkg::CfgAddrW-1:0] idx,
                           input logic [brd_pkg::DimRegW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_shape(input logic [brd_pkg::DimRegW-1:0] w,
                           input logic [brd_pkg::DimRegW-1:0] h, input logic four);
    write_reg(brd_pkg::RegWidth, w);
    write_reg(brd_pkg::RegHeight, h);
    write_reg(brd_pkg::RegFour, {{(brd_pkg::DimRegW-1){1'b0}}, four});
    reg_width = w;
    reg_height = h;
    reg_four = four;
  endtask

  task automatic drain();
    while (items_waiting.size() != 0 || s_axis_tvalid || runs_due.size() != 0)
      @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // One image: a start command, a mostly well-formed command stream and one of
  // several endings (end of bitmap, marked last byte, truncation, trailing bytes).
  task automatic gen_image(output int unsigned used);
    logic [brd_pkg::ByteW-1:0] s[$];
    int unsigned               k, nb, cut, ending;
    logic                      last;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(24, 1)) s.push_back(byte_t'($urandom));
    end else begin
      repeat ($urandom_range(6, 1)) begin
        case ($urandom_range(7))
          0, 1, 2: begin
            k = ($urandom_range(3) == 0) ? $urandom_range(255, 1) : $urandom_range(12, 1);
            s.push_back(k[brd_pkg::ByteW-1:0]);
            s.push_back(byte_t'($urandom));
          end
          3: begin
            s.push_back(brd_pkg::EscLead);
            s.push_back(brd_pkg::EscEol);
          end
          4: begin
            s.push_back(brd_pkg::EscLead);
            s.push_back(brd_pkg::EscDelta);
            s.push_back(byte_t'(($urandom_range(5) == 0) ? $urandom_range(255)
                                                          : $urandom_range(8)));
            s.push_back(byte_t'(($urandom_range(5) == 0) ? $urandom_range(255)
                                                          : $urandom_range(3)));
          end
          default: begin
            k = ($urandom_range(4) == 0) ? $urandom_range(255, 3) : $urandom_range(10, 3);
            nb = reg_four ? (k + 1) / 2 : k;
            s.push_back(brd_pkg::EscLead);
            s.push_back(k[brd_pkg::ByteW-1:0]);
            repeat (nb) s.push_back(byte_t'($urandom));
            if (nb % 2 == 1)
              s.push_back(byte_t'($urandom));
          end
        endcase
      end
    end
    ending = $urandom_range(3);
    if (ending == 0 || ending == 3) begin
      s.push_back(brd_pkg::EscLead);
      s.push_back(brd_pkg::EscEob);
      if (ending == 3)
        repeat ($urandom_range(3, 1)) s.push_back(byte_t'($urandom));
    end else if (ending == 2 && s.size() > 1) begin
      cut = $urandom_range(s.size() - 1, 1);
      while (s.size() > cut)
        void'(s.pop_back());
    end
    send(brd_pkg::CmdStart, byte_t'($urandom), 1'($urandom));
    for (int i = 0; i < s.size(); i++) begin
      if ($urandom_range(24) == 0)
        push_item(brd_pkg::CmdPalette, byte_t'($urandom), 1'($urandom), byte_t'($urandom),
                  rgb_t'($urandom));
      if ($urandom_range(39) == 0)
        send(CmdUnused, byte_t'($urandom), 1'($urandom));
      last = (i == s.size() - 1) && (ending != 0);
      send(brd_pkg::CmdData, s[i], last);
    end
    used = s.size();
  endtask

  task automatic run_phase(input logic [brd_pkg::DimRegW-1:0] w,
                           input logic [brd_pkg::DimRegW-1:0] h, input logic four,
                           input int unsigned budget, input logic calm);
    int unsigned sent, used;
    set_shape(w, h, four);
    if (calm) begin
      src_gap_pct = 0;
      dst_gap_pct = 0;
    end else begin
      case ($urandom_range(2))
        0: src_gap_pct = 0;
        1: src_gap_pct = 10;
        default: src_gap_pct = 30;
      endcase
      case ($urandom_range(2))
        0: dst_gap_pct = 0;
        1: dst_gap_pct = 10;
        default: dst_gap_pct = 30;
      endcase
    end
    sent = 0;
    while (sent < budget) begin
      gen_image(used);
      sent += used;
    end
    drain();
  endtask

  initial begin : stimulus
    logic [brd_pkg::RgbW-1:0] rgb;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    src_gap_pct = 20;
    dst_gap_pct = 15;
    set_shape(13'd16, 13'd12, 1'b0);
    for (int i = 0; i < 256; i++) begin
      rgb = (i == 0) ? 24'hFFFFFF : (i == 255) ? 24'h000000 : rgb_t'($urandom);
      push_item(brd_pkg::CmdPalette, byte_t'($urandom), 1'($urandom), i[brd_pkg::ByteW-1:0],
                rgb);
    end
    drain();

    send(brd_pkg::CmdStart, 8'h00, 1'b0);
    send(brd_pkg::CmdData, 8'd1, 1'b0);
    send(brd_pkg::CmdData, 8'hFF, 1'b0);
    send(brd_pkg::CmdData, 8'hFF, 1'b0);
    send(brd_pkg::CmdData, 8'h00, 1'b0);
    send(brd_pkg::CmdData, brd_pkg::EscLead, 1'b0);
    send(brd_pkg::CmdData, brd_pkg::EscEol, 1'b0);
    send(brd_pkg::CmdData, brd_pkg::EscLead, 1'b0);
    send(brd_pkg::CmdData, brd_pkg::EscDelta, 1'b0);
    send(brd_pkg::CmdData, 8'd5, 1'b0);
    send(brd_pkg::CmdData, 8'd3, 1'b0);
    send(brd_pkg::CmdData, brd_pkg::EscLead, 1'b0);
    send(brd_pkg::CmdData, 8'd3, 1'b0);
    repeat (4) send(brd_pkg::CmdData, byte_t'($urandom), 1'b0);
    push_item(brd_pkg::CmdPalette, 8'h00, 1'b1, 8'h10, 24'h000000);
    send(CmdUnused, 8'h00, 1'b1);
    send(brd_pkg::CmdData, brd_pkg::EscLead, 1'b0);
    send(brd_pkg::CmdData, brd_pkg::EscEob, 1'b0);
    send(brd_pkg::CmdData, 8'h42, 1'b1);
    drain();

    set_shape(13'd16, 13'd12, 1'b1);
    send(brd_pkg::CmdStart, 8'h00, 1'b0);
    send(brd_pkg::CmdData, brd_pkg::EscLead, 1'b0);
    send(brd_pkg::CmdData, 8'd3, 1'b0);
    send(brd_pkg::CmdData, 8'h12, 1'b0);
    send(brd_pkg::CmdData, 8'h34, 1'b0);
    send(brd_pkg::CmdData, 8'd7, 1'b1);
    drain();

    run_phase(13'd8191, 13'd8191, 1'b0, 30, 1'b0);
    run_phase(13'd4096, 13'd4096, 1'b1, 30, 1'b0);
    run_phase(13'd0, 13'd5, 1'b0, 15, 1'b0);
    run_phase(13'd3, 13'd0, 1'b1, 15, 1'b0);
    run_phase(13'd1, 13'd1, 1'b1, 20, 1'b0);
    repeat (4)
      run_phase(dim_t'($urandom_range(40, 1)), dim_t'($urandom_range(20, 1)), 1'($urandom),
                30, 1'b0);
    run_phase(13'd20, 13'd10, 1'b0, 30, 1'b1);

    if (mismatches == 0 && runs_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
